// File: design/cpa_pkg.sv
package cpa_pkg;

	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MAX_PAGES_DEF = 1024;

	localparam int BASE_W = 52;
	localparam int POOL_W = 11;
	localparam int CFG_W = 52;

	localparam logic CFG_POOL_BASE_PAGE = 1'b0;
	localparam logic CFG_POOL_PAGES = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOT_READY = 3'd1,
		ST_ZERO_SIZE = 3'd2,
		ST_NO_SPACE = 3'd3,
		ST_BAD_ADDRESS = 3'd4,
		ST_NOT_START = 3'd5
	} cpa_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_APPLY,
		S_DONE
	} cpa_state_t;

endpackage

// File: design/cpa_cell.sv
module cpa_cell #(
	parameter int MAX_PAGES = cpa_pkg::MAX_PAGES_DEF,
	parameter int IDX = 0,
	localparam int IW = $clog2(MAX_PAGES),
	localparam int CW = $clog2(MAX_PAGES + 1),
	localparam int HW = CW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] need,
	input  logic [CW-1:0] total,
	input  logic [IW-1:0] sel_idx,
	input  logic [HW-1:0] lo,
	input  logic [HW-1:0] hi,
	input  logic          mark_en,
	input  logic          mark_val,
	input  logic [CW-1:0] rl_val,
	input  logic          in_found,
	input  logic [IW-1:0] in_end,
	input  logic [CW-1:0] in_run,
	input  logic [CW-1:0] in_len,
	output logic          out_found,
	output logic [IW-1:0] out_end,
	output logic [CW-1:0] out_run,
	output logic [CW-1:0] out_len
);

	localparam logic [IW-1:0] ID = IW'(IDX);
	localparam logic [CW-1:0] IDC = CW'(IDX);
	localparam logic [HW-1:0] IDH = HW'(IDX);

	logic          used_q;
	logic [CW-1:0] rl_q;
	logic          free_here;
	logic [CW-1:0] run_inc;
	logic          hit;
	logic          in_range;

	assign free_here = !used_q && (IDC < total);
	assign run_inc = in_run + CW'(1);
	assign hit = !in_found && free_here && (run_inc == need);
	assign in_range = (IDH >= lo) && (IDH < hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			rl_q <= '0;
		end else if (mark_en) begin
			if (in_range)
				used_q <= mark_val;
			if (lo[IW-1:0] == ID && lo[HW-1:IW] == '0)
				rl_q <= rl_val;
		end
	end

	always_ff @(posedge clk) begin
		out_found <= in_found | hit;
		out_end <= in_found ? in_end : ID;
		out_run <= (!in_found && free_here) ? run_inc : '0;
		out_len <= (sel_idx == ID) ? rl_q : in_len;
	end

endmodule

// File: design/contiguous_page_allocator.sv
// Sequencing: not-ready, zero-size, oversize and address faults are settled in the check state
// and go straight to the result; scanned requests end there when they find no space or not block
// start, and pass through an apply state that updates the bitmap when they succeed. The scan wave
// runs one page cell per cycle down the chain of registered cells.
// Throughput: one request at a time; the next transfer is taken the cycle after the result has
// gone.
// Reset: page bitmap, run lengths, config and FSM state clear at once; no clearing pass.
module contiguous_page_allocator #(
	parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES = cpa_pkg::MAX_PAGES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [cpa_pkg::CFG_W-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic [31:0]              request_bytes,
	input  logic [63:0]              release_address,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               status,
	output logic [63:0]              block_address,
	output logic [22:0]              granted_bytes
);

	localparam int PB = $clog2(PAGE_BYTES);
	localparam int IW = $clog2(MAX_PAGES);
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam int HW = CW + 1;

	cpa_pkg::cpa_state_t state_q, state_n;

	logic [cpa_pkg::BASE_W-1:0] base_page_q;
	logic [cpa_pkg::POOL_W-1:0] pool_pages_q;
	logic                       op_q;
	logic [31:0]                bytes_q;
	logic [63:0]                addr_q;
	logic [CW-1:0]              need_q;
	logic [IW-1:0]              idx_q;
	logic [CW-1:0]              cnt_q;
	logic [HW-1:0]              lo_q;
	logic [HW-1:0]              hi_q;
	logic                       mark_val_q;
	logic [CW-1:0]              rl_val_q;
	logic [2:0]                 status_q;
	logic [63:0]                block_address_q;
	logic [22:0]                granted_q;
	logic                       mark_en;

	logic [CW-1:0] total;
	logic [32:0]   need_full;
	logic [63:0]   base;
	logic [63:0]   off;
	logic          bad_addr;
	logic [HW-1:0] start;
	logic          scan_end;

	logic          ch_found [0:MAX_PAGES];
	logic [IW-1:0] ch_end   [0:MAX_PAGES];
	logic [CW-1:0] ch_run   [0:MAX_PAGES];
	logic [CW-1:0] ch_len   [0:MAX_PAGES];

	assign total = (32'(pool_pages_q) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pool_pages_q);
	assign need_full = (33'(bytes_q) + 33'(PAGE_BYTES - 1)) >> PB;
	assign base = 64'({base_page_q, {PB{1'b0}}});
	assign off = addr_q - base;
	assign bad_addr = (addr_q < base) || (off >= (64'(total) << PB)) || (off[PB-1:0] != '0);
	assign start = HW'(ch_end[MAX_PAGES]) - HW'(need_q) + HW'(1);
	assign scan_end = (cnt_q == CW'(MAX_PAGES));

	assign ch_found[0] = 1'b0;
	assign ch_end[0] = '0;
	assign ch_run[0] = '0;
	assign ch_len[0] = '0;

	for (genvar i = 0; i < MAX_PAGES; i++) begin : g_cell
		cpa_cell #(.MAX_PAGES(MAX_PAGES), .IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.need(need_q),
			.total(total),
			.sel_idx(idx_q),
			.lo(lo_q),
			.hi(hi_q),
			.mark_en(mark_en),
			.mark_val(mark_val_q),
			.rl_val(rl_val_q),
			.in_found(ch_found[i]),
			.in_end(ch_end[i]),
			.in_run(ch_run[i]),
			.in_len(ch_len[i]),
			.out_found(ch_found[i+1]),
			.out_end(ch_end[i+1]),
			.out_run(ch_run[i+1]),
			.out_len(ch_len[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_page_q <= '0;
			pool_pages_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpa_pkg::CFG_POOL_BASE_PAGE: base_page_q <= cfg_data;
				cpa_pkg::CFG_POOL_PAGES: pool_pages_q <= cfg_data[cpa_pkg::POOL_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cpa_pkg::S_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cpa_pkg::S_IDLE:
				if (in_valid)
					state_n = cpa_pkg::S_CHECK;
			cpa_pkg::S_CHECK: begin
				if (pool_pages_q == '0)
					state_n = cpa_pkg::S_DONE;
				else if (!op_q)
					state_n = (bytes_q == '0 || need_full > 33'(total)) ?
						cpa_pkg::S_DONE : cpa_pkg::S_SCAN;
				else
					state_n = bad_addr ? cpa_pkg::S_DONE : cpa_pkg::S_SCAN;
			end
			cpa_pkg::S_SCAN:
				if (scan_end) begin
					if (!op_q)
						state_n = ch_found[MAX_PAGES] ? cpa_pkg::S_APPLY : cpa_pkg::S_DONE;
					else
						state_n = (ch_len[MAX_PAGES] == '0) ? cpa_pkg::S_DONE
							: cpa_pkg::S_APPLY;
				end
			cpa_pkg::S_APPLY:
				state_n = cpa_pkg::S_DONE;
			cpa_pkg::S_DONE:
				if (out_ready)
					state_n = cpa_pkg::S_IDLE;
			default:
				state_n = cpa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == cpa_pkg::S_IDLE);
		out_valid = (state_q == cpa_pkg::S_DONE);
		mark_en = (state_q == cpa_pkg::S_APPLY);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			cpa_pkg::S_IDLE: begin
				op_q <= opcode;
				bytes_q <= request_bytes;
				addr_q <= release_address;
			end
			cpa_pkg::S_CHECK: begin
				cnt_q <= '0;
				need_q <= CW'(need_full);
				idx_q <= off[PB+IW-1:PB];
				block_address_q <= '0;
				granted_q <= '0;
				if (pool_pages_q == '0)
					status_q <= cpa_pkg::ST_NOT_READY;
				else if (!op_q && bytes_q == '0)
					status_q <= cpa_pkg::ST_ZERO_SIZE;
				else if (!op_q)
					status_q <= cpa_pkg::ST_NO_SPACE;
				else
					status_q <= cpa_pkg::ST_BAD_ADDRESS;
			end
			cpa_pkg::S_SCAN: begin
				cnt_q <= cnt_q + CW'(1);
				if (scan_end) begin
					if (!op_q) begin
						lo_q <= start;
						hi_q <= start + HW'(need_q);
						mark_val_q <= 1'b1;
						rl_val_q <= need_q;
						if (ch_found[MAX_PAGES]) begin
							status_q <= cpa_pkg::ST_OK;
							block_address_q <= base + (64'(start) << PB);
							granted_q <= 23'(64'(need_q) << PB);
						end
					end else begin
						lo_q <= HW'(idx_q);
						hi_q <= HW'(idx_q) + HW'(ch_len[MAX_PAGES]);
						mark_val_q <= 1'b0;
						rl_val_q <= '0;
						status_q <= (ch_len[MAX_PAGES] == '0) ? cpa_pkg::ST_NOT_START
							: cpa_pkg::ST_OK;
					end
				end
			end
			cpa_pkg::S_APPLY, cpa_pkg::S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign status = status_q;
	assign block_address = block_address_q;
	assign granted_bytes = granted_q;

endmodule

// File: design/cpa_checker.sv
module cpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [63:0] block_address,
	input logic [22:0] granted_bytes
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block_address))
		else $error("result changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("transfer taken while result pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after transfer");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= cpa_pkg::ST_NOT_START)
		else $error("status out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cpa_pkg::ST_OK |-> block_address == '0 && granted_bytes == '0)
		else $error("failure result carries data");

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (.*);
